[hw/rtl/psep_pkg.sv]
`timescale 1ns / 1ps

package psep_pkg;

    // ASCII space, the only byte that is collapsed.
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
    } out_item_t;

    // Spacing state carried from one item to the next.
    typedef struct packed {
        logic prev_was_space;
        logic space_pending;
    } sep_state_t;

    // Everything one item produces: up to two results and the next state.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
        sep_state_t state_next;
    } sep_result_t;

    // True for the 32 printable ASCII punctuation characters.
    function automatic logic is_punct(input logic [7:0] b);
        logic hit;
        begin
            hit = ((b >= 8'h21) && (b <= 8'h2F)) ||
                  ((b >= 8'h3A) && (b <= 8'h40)) ||
                  ((b >= 8'h5B) && (b <= 8'h60)) ||
                  ((b >= 8'h7B) && (b <= 8'h7E));
            return hit;
        end
    endfunction

endpackage

[hw/rtl/punctuation_separator.sv]
`timescale 1ns / 1ps

// Punctuation separator: one text byte enters per item and 0, 1 or 2 bytes
// leave, one per output item. Punctuation gets a space on each side, space
// runs collapse, leading and trailing spaces vanish; the item flagged is_last
// always yields a result with end_of_text set (a bare marker with byte_valid
// low if it produced no byte), and the spacing state then starts over for the
// next text. An item waits in the input register and then puts its results in the
// output queue, so with the output never stalled the block sustains one item per
// cycle for plain bytes; when every byte is punctuation each item yields two
// results, and the single output port, one result per cycle, sets the pace.
module punctuation_separator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  psep_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output psep_pkg::out_item_t  out_item
);
    import psep_pkg::*;

    logic         in_full_reg;
    logic         in_full_next;
    in_item_t     in_item_reg;
    sep_state_t   state_reg;
    sep_result_t  result;
    logic         room;
    logic         fire;
    logic [1:0]   push_count;

    // The held item is processed once the queue can take both its results.
    assign fire       = in_full_reg && room;
    assign in_stall   = in_full_reg && !room;
    assign push_count = fire ? result.count : 2'd0;

    assign in_full_next = (in_valid && !in_stall) || (in_full_reg && !fire);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
    end

    // Spacing state advances with each processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_was_space <= 1'b1;
            state_reg.space_pending  <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= result.state_next;
        end
    end

    psep_classify u_classify (
        .item   (in_item_reg),
        .state  (state_reg),
        .result (result)
    );

    psep_out_queue u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (result.first),
        .push_second (result.second),
        .room        (room),
        .valid       (out_valid),
        .stall       (out_stall),
        .item        (out_item)
    );

    // Stall is only raised while an item is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg)
        else $error("input stalled with empty input register");

    // After the last byte of a text the spacing state is back at its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_item_reg.is_last) |=>
            (state_reg.prev_was_space && !state_reg.space_pending))
        else $error("state not restarted after end of text");

    // A pending space always follows a space.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.space_pending |-> state_reg.prev_was_space)
        else $error("pending space without preceding space");

endmodule

[hw/rtl/psep_classify.sv]
`timescale 1ns / 1ps

module psep_classify (
    input  psep_pkg::in_item_t    item,
    input  psep_pkg::sep_state_t  state,
    output psep_pkg::sep_result_t result
);
    import psep_pkg::*;

    logic punct;
    logic space;
    logic lead_space;

    assign punct = is_punct(item.in_byte);
    assign space = (item.in_byte == SPACE_BYTE);

    // A punctuation byte brings its own leading space unless one was just seen;
    // any other visible byte only flushes a pending space.
    assign lead_space = punct ? (state.space_pending || !state.prev_was_space)
                              : state.space_pending;

    always_comb
    begin
        result = '0;
        if (space)
        begin
            // A space emits nothing; the first of a run becomes pending.
            result.count                     = 2'd0;
            result.state_next.prev_was_space = 1'b1;
            result.state_next.space_pending  = state.space_pending ||
                                               !state.prev_was_space;
        end
        else
        begin
            // The space-then-byte case uses both slots, otherwise the byte goes first.
            if (lead_space)
            begin
                result.count              = 2'd2;
                result.first.out_byte     = SPACE_BYTE;
                result.first.byte_valid   = 1'b1;
                result.second.out_byte    = item.in_byte;
                result.second.byte_valid  = 1'b1;
            end
            else
            begin
                result.count              = 2'd1;
                result.first.out_byte     = item.in_byte;
                result.first.byte_valid   = 1'b1;
            end
            // Punctuation leaves a trailing space pending behind it.
            result.state_next.prev_was_space = punct;
            result.state_next.space_pending  = punct;
        end

        // End of text: mark the last result, or emit a bare marker.
        if (item.is_last)
        begin
            unique case (result.count)
                2'd0:
                begin
                    result.count             = 2'd1;
                    result.first.end_of_text = 1'b1;
                end
                2'd1:    result.first.end_of_text  = 1'b1;
                default: result.second.end_of_text = 1'b1;
            endcase
            result.state_next.prev_was_space = 1'b1;
            result.state_next.space_pending  = 1'b0;
        end
    end

endmodule

[hw/rtl/psep_out_queue.sv]
`timescale 1ns / 1ps

module psep_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_count,
    input  psep_pkg::out_item_t  push_first,
    input  psep_pkg::out_item_t  push_second,
    output logic                 room,
    output logic                 valid,
    input  logic                 stall,
    output psep_pkg::out_item_t  item
);
    import psep_pkg::*;

    out_item_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_plus1;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic                     pop;

    // Room for the largest burst of one item, judged before this cycle's pop.
    assign room  = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign valid = (count_reg != '0);
    assign item  = entry_reg[rd_ptr_reg];
    assign pop   = valid && !stall;

    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + QUEUE_PTR_W'(push_count);
    assign rd_ptr_next  = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
    assign count_next   = count_reg + QUEUE_CNT_W'(push_count)
                          - QUEUE_CNT_W'(pop);

    // Entry storage: up to two writes per cycle at consecutive slots.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push_second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // Pushes only arrive when room was reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> room)
        else $error("push into full result queue");

    // With no push and no pop, the fill count holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("fill count changed while idle");

endmodule

[tb/tb_punctuation_separator.sv]
`timescale 1ns / 1ps

module tb_punctuation_separator;

    import psep_pkg::*;

    typedef logic [7:0] text_q_t[$];

    // Tracks the spacing of the text stream and holds the bytes still owed by the block.
    class spaced_text_checker;
        out_item_t  owed_bytes[$];
        out_item_t  step_bytes[$];
        logic       after_space;
        logic       space_held;
        int         mismatches;
        int         results_seen;
        int         items_seen;
        int         texts_seen;
        int         bare_marks;

        function new();
            after_space  = 1'b1;
            space_held   = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            items_seen   = 0;
            texts_seen   = 0;
            bare_marks   = 0;
        endfunction

        // Printable ASCII that is neither a digit nor a letter.
        function logic is_punct_mark(logic [7:0] b);
            logic digit;
            logic upper;
            logic lower;
            digit = (b >= 8'h30) && (b <= 8'h39);
            upper = (b >= 8'h41) && (b <= 8'h5A);
            lower = (b >= 8'h61) && (b <= 8'h7A);
            return (b >= 8'h21) && (b <= 8'h7E) && !digit && !upper && !lower;
        endfunction

        // Appends one result to those caused by the current input item.
        function void add_step(out_item_t r);
            step_bytes.insert(step_bytes.size(), r);
        endfunction

        // Appends one result to the tail of the owed list.
        function void add_owed(out_item_t r);
            owed_bytes.insert(owed_bytes.size(), r);
        endfunction

        // Takes one byte of the spaced text; spaces only arm a held space.
        function void take_spaced(logic [7:0] c);
            out_item_t r;
            if (c == SPACE_BYTE)
            begin
                if (!after_space)
                    space_held = 1'b1;
                after_space = 1'b1;
            end
            else
            begin
                if (space_held)
                begin
                    r = '{SPACE_BYTE, 1'b1, 1'b0};
                    add_step(r);
                end
                space_held = 1'b0;
                r = '{c, 1'b1, 1'b0};
                add_step(r);
                after_space = 1'b0;
            end
        endfunction

        // Works out the results of one accepted input item.
        function void note_item_in(in_item_t it);
            out_item_t r;
            step_bytes.delete();
            items_seen++;
            if (is_punct_mark(it.in_byte))
            begin
                take_spaced(SPACE_BYTE);
                take_spaced(it.in_byte);
                take_spaced(SPACE_BYTE);
            end
            else
            begin
                take_spaced(it.in_byte);
            end
            // The last byte always closes the text, with a bare marker if nothing came out.
            if (it.is_last)
            begin
                texts_seen++;
                if (step_bytes.size() == 0)
                begin
                    r = '{8'h00, 1'b0, 1'b1};
                    add_step(r);
                    bare_marks++;
                end
                else
                begin
                    step_bytes[step_bytes.size() - 1].end_of_text = 1'b1;
                end
                after_space = 1'b1;
                space_held  = 1'b0;
            end
            foreach (step_bytes[k])
                add_owed(step_bytes[k]);
        endfunction

        // Compares one accepted result with the oldest owed one.
        function void check_item_out(out_item_t got);
            out_item_t want;
            results_seen++;
            if (owed_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result byte=%02h valid=%0b end=%0b arrived with none owed",
                             got.out_byte, got.byte_valid, got.end_of_text);
                return;
            end
            want = owed_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.end_of_text !== want.end_of_text)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d: expected byte=%02h valid=%0b end=%0b,",
                              " got byte=%02h valid=%0b end=%0b"},
                             results_seen, want.out_byte, want.byte_valid, want.end_of_text,
                             got.out_byte, got.byte_valid, got.end_of_text);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;

    spaced_text_checker sb = new();

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int input_held_cycles = 0;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 360;

    punctuation_separator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #1 clk = ~clk;

    // Generous bound on the whole run.
    initial
    begin
        #800000;
        $display("Some tests failed");
        $finish;
    end

    // Watch both channels at each edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item_in(in_item);
            if (in_valid && in_stall)
                input_held_cycles++;
            if (out_valid && !out_stall)
                sb.check_item_out(out_item);
        end
    end

    // Output side: random stalls, or a long hold when one is asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Mix of spaces, punctuation, letters and arbitrary bytes.
    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(99);
        if (r < 28)
        begin
            b = SPACE_BYTE;
        end
        else if (r < 52)
        begin
            b = 8'($urandom_range(8'h7E, 8'h21));
            while (!sb.is_punct_mark(b))
                b = 8'($urandom_range(8'h7E, 8'h21));
        end
        else if (r < 82)
        begin
            b = 8'($urandom_range(8'h7A, 8'h61));
        end
        else
        begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    // Offers one item after an optional idle gap and waits until it is taken.
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{b, last};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_fixed_text(input text_q_t t);
        foreach (t[i])
            send_item(t[i], i == t.size() - 1);
    endtask

    task automatic send_random_text(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_text_byte(), i == len - 1);
    endtask

    // Stops sending and waits until every owed result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int sent;
        int len;
        sent = 0;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        while (sent < PHASE_ITEMS)
        begin
            len = ($urandom_range(99) < 85) ? $urandom_range(12, 1)
                                            : $urandom_range(48, 13);
            send_random_text(len);
            sent += len;
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Leading spaces, a comma, a space run and trailing spaces ending in a bare marker.
        send_fixed_text('{8'h20, 8'h20, 8'h61, 8'h2C, 8'h20, 8'h62, 8'h20, 8'h20});
        // Single punctuation mark as a whole text.
        send_fixed_text('{8'h21});
        // Byte extremes and other whitespace pass through; text ends on punctuation.
        send_fixed_text('{8'h00, 8'hFF, 8'h09, 8'h0A, 8'h7E});
        // A text that is one space yields only the end marker.
        send_fixed_text('{8'h20});
        // Adjacent punctuation next to a real space.
        send_fixed_text('{8'h41, 8'h2E, 8'h2E, 8'h20, 8'h42});
        // Single plain byte.
        send_fixed_text('{8'h7A});
        wait_drained();

        run_phase(0, 0);
        run_phase(50, 0);
        run_phase(0, 50);
        run_phase(26, 26);

        // Block the output for a long stretch while the input keeps coming.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_ask     = hold_ask + 1;
        send_random_text(60);
        wait_drained();

        repeat (20) @(posedge clk);

        $display("Checked %0d texts: %0d input items, %0d results, %0d bare end markers.",
                 sb.texts_seen, sb.items_seen, sb.results_seen, sb.bare_marks);
        $display("Idle and stall mixes from none to half; input held off for %0d cycles.",
                 input_held_cycles);
        if (sb.mismatches == 0 && sb.owed_bytes.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.mismatches, sb.owed_bytes.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
